FILE: hw/rtl/mwia_pkg.sv
package mwia_pkg;

   // Field widths of one request and one result.
   localparam int CommandWidth = 4;
   localparam int WidthSelWidth = 2;
   localparam int OperandWidth = 64;
   localparam int ShiftWidth = 6;
   localparam int HalfWidth = OperandWidth / 2;

   // Packed request is 140 bits, padded with zeros to 144.
   localparam int ReqBits = CommandWidth + WidthSelWidth + 2 * OperandWidth + ShiftWidth;
   localparam int ReqDataWidth = ((ReqBits + 7) / 8) * 8;
   localparam int RspDataWidth = OperandWidth;

   // Opcodes carried in the command field.
   typedef enum logic [CommandWidth-1:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_AND    = 4'd3,
      OP_OR     = 4'd4,
      OP_XOR    = 4'd5,
      OP_ANDNOT = 4'd6,
      OP_EQ     = 4'd7,
      OP_LTS    = 4'd8,
      OP_GTS    = 4'd9,
      OP_NOT    = 4'd10,
      OP_NEG    = 4'd11,
      OP_SRA    = 4'd12,
      OP_SRL    = 4'd13,
      OP_SLL    = 4'd14
   } op_type;

   // Word width codes.
   typedef enum logic [WidthSelWidth-1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_type;

   // One registered request. Members run from the high end down, so the
   // command sits in the low bits as it does on the bus.
   typedef struct packed {
      logic [ShiftWidth-1:0]    shift_amount;
      logic [OperandWidth-1:0]  operand_b;
      logic [OperandWidth-1:0]  operand_a;
      logic [WidthSelWidth-1:0] width_sel;
      logic [CommandWidth-1:0]  command;
   } request_type;

   // What the operation stage hands to the final stage.
   typedef struct packed {
      logic                    is_mul;
      logic [OperandWidth-1:0] mask;
      logic [OperandWidth-1:0] logic_result;
      logic [OperandWidth-1:0] prod_ll;
      logic [HalfWidth-1:0]    prod_lh;
      logic [HalfWidth-1:0]    prod_hl;
   } stage2_type;

   // All ones at the selected width.
   function automatic logic [OperandWidth-1:0] width_mask(input logic [WidthSelWidth-1:0] wsel);
      logic [OperandWidth-1:0] m;
      case (width_type'(wsel))
         WIDTH_8:  m = 64'h0000_0000_0000_00FF;
         WIDTH_16: m = 64'h0000_0000_0000_FFFF;
         WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/mwia_ops.sv
module mwia_ops (
   input  mwia_pkg::request_type req,
   output mwia_pkg::stage2_type  ops
);
   import mwia_pkg::*;

   logic [OperandWidth-1:0] mask;
   logic [OperandWidth-1:0] sign;
   logic [OperandWidth-1:0] a;
   logic [OperandWidth-1:0] b;
   logic [OperandWidth-1:0] a_biased;
   logic [OperandWidth-1:0] b_biased;
   logic                    a_neg;
   logic [OperandWidth-1:0] sra_fill;
   logic [OperandWidth-1:0] r;

   // Cut operands to the width and find the sign position.
   always_comb begin
      mask = width_mask(req.width_sel);
      sign = mask ^ (mask >> 1);
      a = req.operand_a & mask;
      b = req.operand_b & mask;
      a_neg = |(a & sign);
      // Flipping the sign bit turns a signed compare into an unsigned one.
      a_biased = a ^ sign;
      b_biased = b ^ sign;
      // Shifting by the width or more leaves mask >> sh at zero, so the fill
      // covers the whole word and the shifted value is already zero.
      sra_fill = a_neg ? (mask & ~(mask >> req.shift_amount)) : '0;
   end

   // Everything except the multiply finishes here.
   always_comb begin
      case (op_type'(req.command))
         OP_ADD:    r = a + b;
         OP_SUB:    r = a - b;
         OP_AND:    r = a & b;
         OP_OR:     r = a | b;
         OP_XOR:    r = a ^ b;
         OP_ANDNOT: r = a & ~b;
         OP_EQ:     r = (a == b) ? mask : '0;
         OP_LTS:    r = (a_biased < b_biased) ? mask : '0;
         OP_GTS:    r = (a_biased > b_biased) ? mask : '0;
         OP_NOT:    r = ~a;
         OP_NEG:    r = '0 - a;
         OP_SRA:    r = (a >> req.shift_amount) | sra_fill;
         OP_SRL:    r = a >> req.shift_amount;
         OP_SLL:    r = a << req.shift_amount;
         default:   r = '0;
      endcase
   end

   // Low half of the product from three 32 by 32 partial products.
   always_comb begin
      ops.is_mul = (op_type'(req.command) == OP_MUL);
      ops.mask = mask;
      ops.logic_result = r & mask;
      ops.prod_ll = OperandWidth'(a[HalfWidth-1:0]) * OperandWidth'(b[HalfWidth-1:0]);
      ops.prod_lh = HalfWidth'(a[HalfWidth-1:0] * b[OperandWidth-1:HalfWidth]);
      ops.prod_hl = HalfWidth'(a[OperandWidth-1:HalfWidth] * b[HalfWidth-1:0]);
   end

endmodule

FILE: hw/rtl/multi_width_integer_alu_top.sv
// Channel   Direction  Ports             Contents
// request   in         req_t*            command, width_sel, operand_a, operand_b, shift_amount
// response  out        rsp_t*            result_value
//
// One request per cycle is accepted while no stall holds the pipeline; rsp_tvalid
// rises once the request has passed the operation register into the result register.
// The three stages are the request register, the operation register that holds the
// partial products of the multiply, and the result register.
// Reset clears the valid bits of all three stages; the payload registers are not reset.
// A stall on the response side holds each full stage, and bubbles fill as they can.
module multi_width_integer_alu_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: command[3:0], width_sel[5:4], operand_a[69:6],
   // operand_b[133:70], shift_amount[139:134], zeros[143:140].
   input  logic [mwia_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: result_value[63:0].
   output logic [mwia_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import mwia_pkg::*;

   logic        s1_v_ff, s1_v_in;
   logic        s2_v_ff, s2_v_in;
   logic        out_v_ff, out_v_in;
   logic        s1_load, s2_load, out_load;
   request_type s1_ff;
   stage2_type  s2_ff, s2_in;
   logic [OperandWidth-1:0] out_ff, out_in;
   logic [HalfWidth-1:0]    cross_sum;
   logic [OperandWidth-1:0] product;

   // Each stage loads when it is empty or the stage after it moves on.
   always_comb begin
      out_load = !out_v_ff || rsp_tready;
      s2_load = !s2_v_ff || out_load;
      s1_load = !s1_v_ff || s2_load;
      s1_v_in = s1_load ? req_tvalid : s1_v_ff;
      s2_v_in = s2_load ? s1_v_ff : s2_v_ff;
      out_v_in = out_load ? s2_v_ff : out_v_ff;
   end

   mwia_ops u_ops (
      .req (s1_ff),
      .ops (s2_in)
   );

   // Add up the partial products and pick the final result.
   always_comb begin
      cross_sum = s2_ff.prod_lh + s2_ff.prod_hl;
      product = s2_ff.prod_ll + {cross_sum, {HalfWidth{1'b0}}};
      out_in = s2_ff.is_mul ? (product & s2_ff.mask) : s2_ff.logic_result;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= request_type'(req_tdata[ReqBits-1:0]);
      end
      if (s2_load) begin
         s2_ff <= s2_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign req_tready = s1_load;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

endmodule

FILE: hw/rtl/mwia_checker.sv
module mwia_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [mwia_pkg::ReqDataWidth-1:0] req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mwia_pkg::RspDataWidth-1:0] rsp_tdata
);
   import mwia_pkg::*;

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Nothing comes out right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With the response side open, an accepted request leads to a valid result.
   assert property (@(posedge clock) disable iff (reset)
      req_acc ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after three cycles");

   // A 64-bit equality of equal operands gives all ones.
   assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tdata[3:0] == OP_EQ) && (req_tdata[5:4] == WIDTH_64)
         && (req_tdata[69:6] == req_tdata[133:70])
         ##1 rsp_tready ##1 rsp_tready |=> rsp_tdata == {RspDataWidth{1'b1}})
      else $error("equality result wrong");

endmodule

bind multi_width_integer_alu_top mwia_checker u_checker (.*);
